// ----- design/fcc_pkg.sv -----
// Shared constants, opcodes and helper functions for the flash-cart command controller.
package fcc_pkg;

   localparam int FLASH_BYTES_DEF = 524288;
   localparam int MAP_ENTRIES     = 16;
   localparam int WINDOW_ENTRIES  = 4;

   localparam logic [1:0] REQ_COMMAND = 2'd0;
   localparam logic [1:0] REQ_READ    = 2'd1;
   localparam logic [1:0] REQ_PRELOAD = 2'd2;

   localparam logic [1:0] SEEK_NONE  = 2'd0;
   localparam logic [1:0] SEEK_READ  = 2'd1;
   localparam logic [1:0] SEEK_WRITE = 2'd2;

   localparam logic [7:0] OP_MAP_SET   = 8'hD0;
   localparam logic [7:0] OP_FLASH_PGM = 8'hD4;
   localparam logic [7:0] OP_SD_A      = 8'h97;
   localparam logic [7:0] OP_SD_B      = 8'hAB;
   localparam logic [7:0] OP_SD_C      = 8'hD5;
   localparam logic [7:0] OP_CL_SHIFT  = 8'hD7;
   localparam logic [7:0] OP_FLASH_A   = 8'h00;
   localparam logic [7:0] OP_FLASH_B   = 8'hB7;
   localparam logic [7:0] OP_STATUS    = 8'hC0;
   localparam logic [7:0] OP_HW_VER    = 8'hD1;
   localparam logic [7:0] OP_ONES      = 8'hC5;
   localparam logic [7:0] OP_MAGIC     = 8'hC7;
   localparam logic [7:0] OP_DUMP      = 8'hDE;
   localparam logic [7:0] OP_CHIP_A    = 8'h90;
   localparam logic [7:0] OP_CHIP_B    = 8'hB8;

   localparam logic [7:0] SD_STOP    = 8'h0C;
   localparam logic [7:0] SD_STAT    = 8'h0D;
   localparam logic [7:0] SD_RD1     = 8'h11;
   localparam logic [7:0] SD_RDM     = 8'h12;
   localparam logic [7:0] SD_WR1     = 8'h18;
   localparam logic [7:0] SD_WRM     = 8'h19;
   localparam logic [7:0] SD_OPCOND  = 8'h29;

   // flash read modes carried in command byte 5
   localparam logic [7:0] MODE_WORD_A  = 8'h00;
   localparam logic [7:0] MODE_WORD_B  = 8'h10;
   localparam logic [7:0] MODE_WORD_C  = 8'h12;
   localparam logic [7:0] MODE_IMAGE_A = 8'h11;
   localparam logic [7:0] MODE_IMAGE_B = 8'h13;

   localparam logic [7:0] PGM_ERASE  = 8'h35;
   localparam logic [7:0] PGM_BYTE   = 8'h63;
   localparam logic [7:0] ERASED     = 8'h30;

   localparam logic [7:0] ST_BUSY    = 8'h77;
   localparam logic [7:0] ST_WRITING = 8'hEE;

   localparam logic [31:0] HW_VERSION  = 32'h81818181;
   localparam logic [31:0] MAGIC_WORD  = 32'h9BCA95A7;
   localparam logic [31:0] CHIP_ID     = 32'h00000FC2;
   localparam logic [23:0] DUMP_ADR_A  = 24'h81BBA5;
   localparam logic [23:0] DUMP_ADR_B  = 24'h8189FF;
   localparam logic [31:0] DUMP_VAL_A  = 32'hEFEFEFEF;
   localparam logic [31:0] DUMP_VAL_B  = 32'h02020202;
   localparam logic [31:0] PAT_STATUS  = 32'h00000800;
   localparam logic [31:0] PAT_OPCOND  = 32'h80000000;

   function automatic logic [7:0] cbyte(input logic [63:0] c, input int k);
      cbyte = c[63-8*k -: 8];
   endfunction

   function automatic logic [31:0] be32(input logic [63:0] c, input int first);
      be32 = {cbyte(c, first), cbyte(c, first+1), cbyte(c, first+2), cbyte(c, first+3)};
   endfunction

   // bit-serial SD response: byte i >= 7 carries pattern bit 31-((i-7) mod 32) in bit 7
   function automatic logic [31:0] resp_word(input logic [31:0] pat, input logic [6:0] w);
      logic [31:0] v;
      logic [8:0]  i;
      logic [4:0]  k;
      v = '0;
      for (int m = 0; m < 4; m++) begin
         i = {w, 2'(m)};
         k = 5'(i - 9'd7);
         if (i >= 9'd7) begin
            v[8*m+7] = pat[5'd31 - k];
         end
      end
      resp_word = v;
   endfunction

endpackage

// ----- design/flash_cart_command_controller.sv -----
// Top level: command decode, SD window translation and flash fetch sequencer.
// Most items give their result straight from decode; a flash word read first does 4
// flash byte reads, and an SD seek through the window first reloads it (16 flash byte
// reads) on a miss. New requests wait while an item is busy or the result register is full.
// One result may wait at the output while the next item is processed.
// Synchronous active-high reset clears control state; flash and window contents
// are undefined until written.
module flash_cart_command_controller #(
   parameter int FLASH_BYTES = fcc_pkg::FLASH_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [63:0] req_command,
   input  logic [18:0] req_load_address,
   input  logic [7:0]  req_load_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_read_data,
   output logic [1:0]  rsp_seek_kind,
   output logic [31:0] rsp_seek_address,
   output logic        rsp_image_word_wanted,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data
);
   localparam int AW = $clog2(FLASH_BYTES);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_TRANS = 4'b0010,
      ST_FETCH = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   state_type   state_ff, state_in;
   logic        ejected_ff, ejected_in;
   logic [63:0] lcmd_ff, lcmd_in;
   logic [31:0] map_ff [fcc_pkg::MAP_ENTRIES];
   logic [31:0] map_in [fcc_pkg::MAP_ENTRIES];
   logic [31:0] ws_ff, ws_in;
   logic [31:0] sect_ff [fcc_pkg::WINDOW_ENTRIES];
   logic [31:0] sect_in [fcc_pkg::WINDOW_ENTRIES];
   logic [7:0]  sd_status_ff, sd_status_in;
   logic [4:0]  shift_ff, shift_in;
   logic [3:0]  msel_ff, msel_in;
   logic [31:0] wadr_ff, wadr_in;
   logic [9:0]  fofs_ff, fofs_in;
   logic [31:0] pat_ff, pat_in;
   logic [6:0]  ridx_ff, ridx_in;

   logic [31:0] cl_ff, cl_in;
   logic [31:0] off_ff, off_in;
   logic [1:0]  kind_ff, kind_in;
   logic [31:0] fbase_ff, fbase_in;
   logic [4:0]  fcnt_ff, fcnt_in;
   logic [4:0]  flen_ff, flen_in;
   logic        fwin_ff, fwin_in;
   logic        rpend_ff, rpend_in;
   logic [3:0]  ridx_b_ff, ridx_b_in;
   logic [31:0] word_ff, word_in;

   logic        res_valid_ff, res_valid_in;
   logic [31:0] res_data_ff, res_data_in;
   logic [1:0]  res_kind_ff, res_kind_in;
   logic [31:0] res_addr_ff, res_addr_in;
   logic        res_img_ff, res_img_in;

   logic        out_valid_ff, out_valid_in;
   logic [31:0] out_data_ff, out_data_in;
   logic [1:0]  out_kind_ff, out_kind_in;
   logic [31:0] out_addr_ff, out_addr_in;
   logic        out_img_ff, out_img_in;

   logic          fl_wr_en;
   logic [AW-1:0] fl_wr_addr;
   logic [7:0]    fl_wr_data;
   logic [AW-1:0] fl_rd_addr;
   logic [7:0]    fl_rd_data;

   fcc_flash_mem #(.DEPTH(FLASH_BYTES), .AW(AW)) u_flash (
      .clock      (clock),
      .wr_en      (fl_wr_en),
      .wr_addr    (fl_wr_addr),
      .wr_data    (fl_wr_data),
      .rd_addr    (fl_rd_addr),
      .rd_data_ff (fl_rd_data)
   );

   assign req_stall = (state_ff != ST_IDLE) || res_valid_ff;
   assign csr_ready = 1'b1;

   assign rsp_valid             = out_valid_ff;
   assign rsp_read_data         = out_data_ff;
   assign rsp_seek_kind         = out_kind_ff;
   assign rsp_seek_address      = out_addr_ff;
   assign rsp_image_word_wanted = out_img_ff;

   always_comb begin
      logic [7:0]  op;
      logic [7:0]  sub;
      logic [7:0]  mapb;
      logic [31:0] adr;
      logic [31:0] fa32;
      logic [31:0] pa32;
      logic [31:0] faddr;
      logic [31:0] lim;
      logic [1:0]  widx;
      logic        hit;
      logic        issue;
      logic [3:0]  nmsel;

      state_in     = state_ff;
      ejected_in   = ejected_ff;
      lcmd_in      = lcmd_ff;
      map_in       = map_ff;
      ws_in        = ws_ff;
      sect_in      = sect_ff;
      sd_status_in = sd_status_ff;
      shift_in     = shift_ff;
      msel_in      = msel_ff;
      wadr_in      = wadr_ff;
      fofs_in      = fofs_ff;
      pat_in       = pat_ff;
      ridx_in      = ridx_ff;
      cl_in        = cl_ff;
      off_in       = off_ff;
      kind_in      = kind_ff;
      fbase_in     = fbase_ff;
      fcnt_in      = fcnt_ff;
      flen_in      = flen_ff;
      fwin_in      = fwin_ff;
      word_in      = word_ff;
      res_valid_in = res_valid_ff;
      res_data_in  = res_data_ff;
      res_kind_in  = res_kind_ff;
      res_addr_in  = res_addr_ff;
      res_img_in   = res_img_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      out_kind_in  = out_kind_ff;
      out_addr_in  = out_addr_ff;
      out_img_in   = out_img_ff;

      op    = fcc_pkg::cbyte(req_command, 0);
      sub   = fcc_pkg::cbyte(req_command, 3);
      mapb  = fcc_pkg::cbyte(req_command, 5);
      adr   = fcc_pkg::be32(req_command, 4) << 9;
      nmsel = req_command[55:52];
      fa32  = {8'h00, req_command[55:32]};
      pa32  = 32'(req_load_address);
      faddr = fbase_ff + 32'(fcnt_ff);
      lim   = ws_ff + 32'd3;
      hit   = (cl_ff >= ws_ff) && (cl_ff < lim);
      widx  = 2'(cl_ff - ws_ff);
      issue = (state_ff == ST_FETCH) && (fcnt_ff < flen_ff);

      fl_wr_en   = 1'b0;
      fl_wr_addr = pa32[AW-1:0];
      fl_wr_data = req_load_byte;
      fl_rd_addr = faddr[AW-1:0];

      if (csr_valid) begin
         ejected_in = csr_data;
      end

      // output register takes the finished result when free or drained
      if (res_valid_ff && (!out_valid_ff || !rsp_stall)) begin
         out_valid_in = 1'b1;
         out_data_in  = res_data_ff;
         out_kind_in  = res_kind_ff;
         out_addr_in  = res_addr_ff;
         out_img_in   = res_img_ff;
         res_valid_in = 1'b0;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end

      // flash byte fetch: issue one read a cycle, capture the byte in the next cycle
      rpend_in  = issue;
      ridx_b_in = fcnt_ff[3:0];
      if (issue) begin
         fcnt_in = fcnt_ff + 5'd1;
      end
      if (rpend_ff) begin
         if (fwin_ff) begin
            sect_in[ridx_b_ff[3:2]][8*ridx_b_ff[1:0] +: 8] = fl_rd_data;
         end else begin
            word_in[8*ridx_b_ff[1:0] +: 8] = fl_rd_data;
         end
         if (ridx_b_ff == 4'(flen_ff - 5'd1)) begin
            state_in = ST_DONE;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && !req_stall) begin
               res_valid_in = 1'b1;
               res_data_in  = '0;
               res_kind_in  = fcc_pkg::SEEK_NONE;
               res_addr_in  = '0;
               res_img_in   = 1'b0;
               case (req_type)
                  fcc_pkg::REQ_COMMAND: begin
                     lcmd_in = req_command;
                     case (op) inside
                        fcc_pkg::OP_MAP_SET: begin
                           map_in[mapb[$clog2(fcc_pkg::MAP_ENTRIES)-1:0]] =
                              fcc_pkg::be32(req_command, 1);
                        end
                        fcc_pkg::OP_FLASH_PGM: begin
                           fl_wr_addr = fa32[AW-1:0];
                           if (fcc_pkg::cbyte(req_command, 7) == fcc_pkg::PGM_ERASE) begin
                              fl_wr_en   = 1'b1;
                              fl_wr_data = fcc_pkg::ERASED;
                           end else if (fcc_pkg::cbyte(req_command, 7) == fcc_pkg::PGM_BYTE) begin
                              fl_wr_en   = 1'b1;
                              fl_wr_data = fcc_pkg::cbyte(req_command, 4);
                           end
                           sd_status_in = '0;
                        end
                        fcc_pkg::OP_SD_A, fcc_pkg::OP_SD_B, fcc_pkg::OP_SD_C: begin
                           case (sub) inside
                              fcc_pkg::SD_STOP: begin
                                 sd_status_in = '0;
                                 wadr_in      = '0;
                                 msel_in      = '0;
                              end
                              fcc_pkg::SD_STAT: begin
                                 pat_in  = fcc_pkg::PAT_STATUS;
                                 ridx_in = '0;
                              end
                              fcc_pkg::SD_RD1, fcc_pkg::SD_RDM, fcc_pkg::SD_WR1: begin
                                 msel_in      = nmsel;
                                 sd_status_in = (sub == fcc_pkg::SD_WR1) ? 8'h00
                                                                         : fcc_pkg::ST_BUSY;
                                 kind_in      = (sub == fcc_pkg::SD_WR1) ? fcc_pkg::SEEK_WRITE
                                                                         : fcc_pkg::SEEK_READ;
                                 if (nmsel != 4'd0) begin
                                    cl_in        = adr >> shift_ff;
                                    off_in       = adr & ~(32'hFFFF_FFFF << shift_ff);
                                    res_valid_in = 1'b0;
                                    state_in     = ST_TRANS;
                                 end else begin
                                    res_kind_in = kind_in;
                                    res_addr_in = adr;
                                 end
                              end
                              fcc_pkg::SD_WRM: begin
                                 sd_status_in = fcc_pkg::ST_WRITING;
                                 wadr_in      = (wadr_ff != 32'd0)
                                              ? wadr_ff + 32'd512
                                              : fcc_pkg::be32(req_command, 4);
                                 msel_in      = nmsel;
                                 res_kind_in  = fcc_pkg::SEEK_WRITE;
                                 res_addr_in  = wadr_in;
                              end
                              fcc_pkg::SD_OPCOND: begin
                                 pat_in  = fcc_pkg::PAT_OPCOND;
                                 ridx_in = '0;
                              end
                              default: begin
                                 pat_in  = '0;
                                 ridx_in = '0;
                              end
                           endcase
                        end
                        fcc_pkg::OP_CL_SHIFT: begin
                           shift_in = 5'(8'd9 + fcc_pkg::cbyte(req_command, 6));
                        end
                        fcc_pkg::OP_FLASH_A, fcc_pkg::OP_FLASH_B: begin
                           sd_status_in = fcc_pkg::ST_BUSY;
                           fofs_in      = '0;
                        end
                        default: begin
                        end
                     endcase
                  end
                  fcc_pkg::REQ_READ: begin
                     case (fcc_pkg::cbyte(lcmd_ff, 0)) inside
                        fcc_pkg::OP_STATUS:  res_data_in = {20'd0, sd_status_ff, 4'd0};
                        fcc_pkg::OP_HW_VER:  res_data_in = fcc_pkg::HW_VERSION;
                        fcc_pkg::OP_SD_A, fcc_pkg::OP_SD_B, fcc_pkg::OP_SD_C: begin
                           res_data_in = fcc_pkg::resp_word(pat_ff, ridx_ff);
                           ridx_in     = ridx_ff + 7'd1;
                        end
                        fcc_pkg::OP_ONES:    res_data_in = 32'hFFFF_FFFF;
                        fcc_pkg::OP_MAGIC:   res_data_in = fcc_pkg::MAGIC_WORD;
                        fcc_pkg::OP_DUMP: begin
                           if (lcmd_ff[55:32] == fcc_pkg::DUMP_ADR_A) begin
                              res_data_in = fcc_pkg::DUMP_VAL_A;
                           end else if (lcmd_ff[55:32] == fcc_pkg::DUMP_ADR_B) begin
                              res_data_in = fcc_pkg::DUMP_VAL_B;
                           end
                        end
                        fcc_pkg::OP_FLASH_A, fcc_pkg::OP_FLASH_B: begin
                           case (fcc_pkg::cbyte(lcmd_ff, 5)) inside
                              fcc_pkg::MODE_WORD_A, fcc_pkg::MODE_WORD_B,
                              fcc_pkg::MODE_WORD_C: begin
                                 fbase_in     = map_ff[0] + fcc_pkg::be32(lcmd_ff, 1)
                                              + 32'(fofs_ff);
                                 fcnt_in      = '0;
                                 flen_in      = 5'd4;
                                 fwin_in      = 1'b0;
                                 fofs_in      = (fofs_ff < 10'd512) ? fofs_ff + 10'd4 : 10'd0;
                                 res_valid_in = 1'b0;
                                 state_in     = ST_FETCH;
                              end
                              fcc_pkg::MODE_IMAGE_A, fcc_pkg::MODE_IMAGE_B: res_img_in = 1'b1;
                              default: begin
                              end
                           endcase
                        end
                        fcc_pkg::OP_CHIP_A, fcc_pkg::OP_CHIP_B: begin
                           res_data_in = ejected_ff ? 32'hFFFF_FFFF : fcc_pkg::CHIP_ID;
                        end
                        default: begin
                        end
                     endcase
                  end
                  fcc_pkg::REQ_PRELOAD: begin
                     fl_wr_en = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_TRANS: begin
            if (hit) begin
               res_valid_in = 1'b1;
               res_data_in  = '0;
               res_kind_in  = kind_ff;
               res_addr_in  = sect_ff[widx] + off_ff;
               res_img_in   = 1'b0;
               state_in     = ST_IDLE;
            end else begin
               // window miss: reload four sector words (16 bytes) from the map
               ws_in    = cl_ff;
               fbase_in = {cl_ff[29:0], 2'b00}
                        + map_ff[msel_ff[$clog2(fcc_pkg::MAP_ENTRIES)-1:0]];
               fcnt_in  = '0;
               flen_in  = 5'd16;
               fwin_in  = 1'b1;
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
         end
         ST_DONE: begin
            res_valid_in = 1'b1;
            res_img_in   = 1'b0;
            if (fwin_ff) begin
               res_data_in = '0;
               res_kind_in = kind_ff;
               res_addr_in = sect_ff[0] + off_ff;
            end else begin
               res_data_in = word_ff;
               res_kind_in = fcc_pkg::SEEK_NONE;
               res_addr_in = '0;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ejected_ff   <= 1'b0;
         lcmd_ff      <= '0;
         for (int i = 0; i < fcc_pkg::MAP_ENTRIES; i++) begin
            map_ff[i] <= '0;
         end
         ws_ff        <= 32'hFFFF_FFFF;
         sd_status_ff <= '0;
         shift_ff     <= '0;
         msel_ff      <= '0;
         wadr_ff      <= '0;
         fofs_ff      <= '0;
         pat_ff       <= '0;
         ridx_ff      <= '0;
         rpend_ff     <= 1'b0;
         fcnt_ff      <= '0;
         flen_ff      <= '0;
         res_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ejected_ff   <= ejected_in;
         lcmd_ff      <= lcmd_in;
         map_ff       <= map_in;
         ws_ff        <= ws_in;
         sd_status_ff <= sd_status_in;
         shift_ff     <= shift_in;
         msel_ff      <= msel_in;
         wadr_ff      <= wadr_in;
         fofs_ff      <= fofs_in;
         pat_ff       <= pat_in;
         ridx_ff      <= ridx_in;
         rpend_ff     <= rpend_in;
         fcnt_ff      <= fcnt_in;
         flen_ff      <= flen_in;
         res_valid_ff <= res_valid_in;
         out_valid_ff <= out_valid_in;
      end
      sect_ff     <= sect_in;
      cl_ff       <= cl_in;
      off_ff      <= off_in;
      kind_ff     <= kind_in;
      fbase_ff    <= fbase_in;
      fwin_ff     <= fwin_in;
      ridx_b_ff   <= ridx_b_in;
      word_ff     <= word_in;
      res_data_ff <= res_data_in;
      res_kind_ff <= res_kind_in;
      res_addr_ff <= res_addr_in;
      res_img_ff  <= res_img_in;
      out_data_ff <= out_data_in;
      out_kind_ff <= out_kind_in;
      out_addr_ff <= out_addr_in;
      out_img_ff  <= out_img_in;
   end
endmodule

// ----- design/fcc_flash_mem.sv -----
// Flash byte store: one write port, one registered read port.
module fcc_flash_mem #(
   parameter int DEPTH = fcc_pkg::FLASH_BYTES_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data_ff
);
   logic [7:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end
endmodule

// ----- tb/fcc_checker.sv -----
// Flash-cart controller checker: predicts each result beat and compares it with the block.
package fcc_tb_pkg;
   localparam logic [7:0] MODE_UNKNOWN = 8'h55;
   localparam logic [7:0] OP_UNKNOWN   = 8'h3C;
   localparam logic [1:0] REQ_UNUSED   = 2'd3;
endpackage

module fcc_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [63:0] req_command,
   input  logic [18:0] req_load_address,
   input  logic [7:0]  req_load_byte,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [31:0] rsp_read_data,
   input  logic [1:0]  rsp_seek_kind,
   input  logic [31:0] rsp_seek_address,
   input  logic        rsp_image_word_wanted,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic        csr_data,
   output int          mismatches,
   output int          waiting
);
   timeunit 1ns;
   timeprecision 1ps;
   import fcc_pkg::*;
   import fcc_tb_pkg::*;

   typedef struct packed {
      logic [31:0] data;
      logic [1:0]  kind;
      logic [31:0] addr;
      logic        image;
   } result_type;

   result_type  pending_results[$];

   logic        ejected;
   logic [63:0] cmd_latch;
   logic [7:0]  flash_mem [0:FLASH_BYTES_DEF-1];
   logic [31:0] map_base [0:MAP_ENTRIES-1];
   logic [31:0] win_first;
   logic [31:0] win_sector [0:WINDOW_ENTRIES-1];
   logic [7:0]  status_reg;
   logic [4:0]  shift_reg;
   logic [3:0]  map_sel;
   logic [31:0] wr_accum;
   logic [9:0]  fl_offset;
   logic [31:0] resp_bits;
   logic [6:0]  resp_pos;

   initial begin
      for (int i = 0; i < FLASH_BYTES_DEF; i++) flash_mem[i] = 8'h00;
      for (int i = 0; i < WINDOW_ENTRIES; i++) win_sector[i] = '0;
   end

   function automatic logic [7:0] byte_at(input logic [63:0] c, input int k);
      return c[63-8*k -: 8];
   endfunction

   function automatic logic [31:0] word_at(input logic [63:0] c, input int k);
      return {byte_at(c, k), byte_at(c, k+1), byte_at(c, k+2), byte_at(c, k+3)};
   endfunction

   function automatic logic [31:0] flash_le_word(input logic [31:0] a);
      logic [31:0] v;
      logic [31:0] p;
      for (int n = 0; n < 4; n++) begin
         p = a + n;
         v[8*n +: 8] = flash_mem[p[18:0]];
      end
      return v;
   endfunction

   function automatic logic [31:0] window_lookup(input logic [3:0] m, input logic [31:0] adr);
      logic [31:0] cl;
      logic [31:0] base;
      logic [31:0] idx;
      cl = adr >> shift_reg;
      if (cl < win_first || cl >= win_first + 32'd3) begin
         base = (cl << 2) + map_base[m];
         win_first = cl;
         for (int n = 0; n < WINDOW_ENTRIES; n++) win_sector[n] = flash_le_word(base + 4*n);
      end
      idx = (cl - win_first) & (WINDOW_ENTRIES - 1);
      return win_sector[idx] + (adr & ((32'd1 << shift_reg) - 32'd1));
   endfunction

   function automatic logic [31:0] serial_word(input logic [6:0] w);
      logic [31:0] v;
      int          i;
      v = '0;
      for (int m = 0; m < 4; m++) begin
         i = w * 4 + m;
         if (i >= 7 && resp_bits[31 - ((i - 7) % 32)]) v[8*m+7] = 1'b1;
      end
      return v;
   endfunction

   function automatic void run_command(input logic [63:0] c, inout result_type r);
      logic [18:0] fa;
      logic [31:0] adr;
      logic [7:0]  sub;
      cmd_latch = c;
      sub = byte_at(c, 3);
      case (byte_at(c, 0))
         OP_MAP_SET: map_base[byte_at(c, 5) & 8'h0F] = word_at(c, 1);
         OP_FLASH_PGM: begin
            fa = 19'({byte_at(c, 1), byte_at(c, 2), byte_at(c, 3)});
            if (byte_at(c, 7) == PGM_ERASE) flash_mem[fa] = ERASED;
            else if (byte_at(c, 7) == PGM_BYTE) flash_mem[fa] = byte_at(c, 4);
            status_reg = '0;
         end
         OP_SD_A, OP_SD_B, OP_SD_C: begin
            case (sub)
               SD_STOP: begin
                  status_reg = '0;
                  wr_accum = '0;
                  map_sel = '0;
               end
               SD_STAT: begin
                  resp_bits = PAT_STATUS;
                  resp_pos = '0;
               end
               SD_RD1, SD_RDM, SD_WR1: begin
                  map_sel = 4'(byte_at(c, 1) >> 4);
                  status_reg = (sub == SD_WR1) ? 8'h00 : ST_BUSY;
                  adr = word_at(c, 4) << 9;
                  if (map_sel != 0) adr = window_lookup(map_sel, adr);
                  r.kind = (sub == SD_WR1) ? SEEK_WRITE : SEEK_READ;
                  r.addr = adr;
               end
               SD_WRM: begin
                  status_reg = ST_WRITING;
                  if (wr_accum != 0) wr_accum = wr_accum + 32'd512;
                  else wr_accum = word_at(c, 4);
                  map_sel = 4'(byte_at(c, 1) >> 4);
                  r.kind = SEEK_WRITE;
                  r.addr = wr_accum;
               end
               SD_OPCOND: begin
                  resp_bits = PAT_OPCOND;
                  resp_pos = '0;
               end
               default: begin
                  resp_bits = '0;
                  resp_pos = '0;
               end
            endcase
         end
         OP_CL_SHIFT: shift_reg = 5'(byte_at(c, 6) + 8'd9);
         OP_FLASH_A, OP_FLASH_B: begin
            status_reg = ST_BUSY;
            fl_offset = '0;
         end
         default: ;
      endcase
   endfunction

   function automatic void run_read(inout result_type r);
      logic [23:0] da;
      case (byte_at(cmd_latch, 0))
         OP_STATUS: r.data = 32'(status_reg) << 4;
         OP_HW_VER: r.data = HW_VERSION;
         OP_SD_A, OP_SD_B, OP_SD_C: begin
            r.data = serial_word(resp_pos);
            resp_pos = resp_pos + 7'd1;
         end
         OP_ONES: r.data = '1;
         OP_MAGIC: r.data = MAGIC_WORD;
         OP_DUMP: begin
            da = {byte_at(cmd_latch, 1), byte_at(cmd_latch, 2), byte_at(cmd_latch, 3)};
            if (da == DUMP_ADR_A) r.data = DUMP_VAL_A;
            else if (da == DUMP_ADR_B) r.data = DUMP_VAL_B;
         end
         OP_FLASH_A, OP_FLASH_B: begin
            case (byte_at(cmd_latch, 5))
               MODE_WORD_A, MODE_WORD_B, MODE_WORD_C: begin
                  r.data = flash_le_word(map_base[0] + word_at(cmd_latch, 1) + 32'(fl_offset));
                  if (fl_offset < 10'd512) fl_offset = fl_offset + 10'd4;
                  else fl_offset = '0;
               end
               MODE_IMAGE_A, MODE_IMAGE_B: r.image = 1'b1;
               default: ;
            endcase
         end
         OP_CHIP_A, OP_CHIP_B: r.data = ejected ? 32'hFFFFFFFF : CHIP_ID;
         default: ;
      endcase
   endfunction

   always @(posedge clock) begin
      result_type want;
      result_type got;
      if (reset) begin
         ejected = 1'b0;
         cmd_latch = '0;
         for (int i = 0; i < MAP_ENTRIES; i++) map_base[i] = '0;
         win_first = '1;
         status_reg = '0;
         shift_reg = '0;
         map_sel = '0;
         wr_accum = '0;
         fl_offset = '0;
         resp_bits = '0;
         resp_pos = '0;
         pending_results.delete();
         mismatches = 0;
      end else begin
         if (csr_valid && csr_ready) ejected = csr_data;
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_read_data, rsp_seek_kind, rsp_seek_address, rsp_image_word_wanted};
            if (pending_results.size() == 0) begin
               $display("%0t: result beat with nothing expected: %p", $time, got);
               mismatches++;
            end else begin
               want = pending_results.pop_front();
               if (got.data !== want.data) begin
                  $display("%0t: read_data expected %h actual %h", $time, want.data, got.data);
                  mismatches++;
               end
               if (got.kind !== want.kind) begin
                  $display("%0t: seek_kind expected %0d actual %0d", $time, want.kind, got.kind);
                  mismatches++;
               end
               if (got.addr !== want.addr) begin
                  $display("%0t: seek_address expected %h actual %h",
                           $time, want.addr, got.addr);
                  mismatches++;
               end
               if (got.image !== want.image) begin
                  $display("%0t: image_word_wanted expected %b actual %b",
                           $time, want.image, got.image);
                  mismatches++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            want = '0;
            case (req_type)
               REQ_COMMAND: run_command(req_command, want);
               REQ_READ:    run_read(want);
               REQ_PRELOAD: flash_mem[req_load_address] = req_load_byte;
               default: ;
            endcase
            pending_results.push_back(want);
         end
      end
      waiting = pending_results.size();
   end
endmodule

// ----- tb/tb_flash_cart_command_controller.sv -----
// Flash-cart controller testbench top: clock, reset, stimulus, stall pressure and verdict.
module tb_flash_cart_command_controller;
   timeunit 1ns;
   timeprecision 1ps;
   import fcc_pkg::*;
   import fcc_tb_pkg::*;

   localparam int LIMIT       = 1000000;
   localparam int PHASE_ITEMS = 400;
   localparam int DRAIN       = 25;
   localparam int HOLD_AT     = 2500;
   localparam int HOLD_LEN    = 400;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_type = '0;
   logic [63:0] req_command = '0;
   logic [18:0] req_load_address = '0;
   logic [7:0]  req_load_byte = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_read_data;
   logic [1:0]  rsp_seek_kind;
   logic [31:0] rsp_seek_address;
   logic        rsp_image_word_wanted;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_data = 1'b0;

   int mismatches;
   int waiting;
   int cycles = 0;
   int sent_beats = 0;
   int rcvd_beats = 0;
   int primary_items = 0;
   int stall_run = 0;
   logic stall_level = 1'b0;

   // stimulus-side view of the state that decides which flash bytes get read
   bit          loaded [0:FLASH_BYTES_DEF-1];
   logic [31:0] base_of_map [0:MAP_ENTRIES-1];
   logic [4:0]  cur_shift = '0;
   logic [9:0]  cur_offset = '0;
   logic [63:0] cur_cmd = '0;
   logic [31:0] last_sector = '0;

   flash_cart_command_controller dut (.*);

   fcc_checker u_checker (.*);

   initial forever #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (rsp_valid && !rsp_stall) rcvd_beats <= rcvd_beats + 1;
      if (cycles == LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // receiver: random stall runs, plus one long hold-off while the sender keeps going
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (cycles >= HOLD_AT && cycles < HOLD_AT + HOLD_LEN) begin
         rsp_stall <= 1'b1;
      end else if (stall_run > 0) begin
         stall_run <= stall_run - 1;
         rsp_stall <= stall_level;
      end else begin
         int r;
         r = $urandom_range(0, 99);
         if (r < 60) begin
            stall_level <= 1'b0;
            stall_run <= $urandom_range(0, 8);
            rsp_stall <= 1'b0;
         end else if (r < 92) begin
            stall_level <= 1'b1;
            stall_run <= $urandom_range(0, 2);
            rsp_stall <= 1'b1;
         end else begin
            stall_level <= 1'b1;
            stall_run <= $urandom_range(10, 40);
            rsp_stall <= 1'b1;
         end
      end
   end

   function automatic logic [7:0] cmd_byte(input logic [63:0] c, input int k);
      return c[63-8*k -: 8];
   endfunction

   function automatic logic [31:0] cmd_word(input logic [63:0] c, input int k);
      return {cmd_byte(c, k), cmd_byte(c, k+1), cmd_byte(c, k+2), cmd_byte(c, k+3)};
   endfunction

   function automatic logic [63:0] with_byte(input logic [63:0] c, input int k,
                                             input logic [7:0] b);
      logic [63:0] v;
      v = c;
      v[63-8*k -: 8] = b;
      return v;
   endfunction

   function automatic logic [63:0] with_word(input logic [63:0] c, input int k,
                                             input logic [31:0] w);
      logic [63:0] v;
      v = c;
      for (int i = 0; i < 4; i++) v[63-8*(k+i) -: 8] = w[31-8*i -: 8];
      return v;
   endfunction

   function automatic logic [63:0] rand_cmd(input logic [7:0] op);
      return with_byte({$urandom, $urandom}, 0, op);
   endfunction

   task automatic send_beat(input logic [1:0] t, input logic [63:0] c,
                            input logic [18:0] la, input logic [7:0] lb);
      int r;
      int gap;
      req_valid <= 1'b1;
      req_type <= t;
      req_command <= c;
      req_load_address <= la;
      req_load_byte <= lb;
      do @(posedge clock); while (req_stall);
      sent_beats++;
      r = $urandom_range(0, 99);
      gap = (r < 65) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_preload(input logic [18:0] a, input logic [7:0] b);
      loaded[a] = 1'b1;
      send_beat(REQ_PRELOAD, {$urandom, $urandom}, a, b);
   endtask

   // never let the block read a flash byte that was never written
   task automatic ensure_loaded(input logic [31:0] a, input int n);
      logic [31:0] p;
      for (int i = 0; i < n; i++) begin
         p = a + i;
         if (!loaded[p[18:0]]) send_preload(p[18:0], 8'($urandom));
      end
   endtask

   task automatic issue_cmd(input logic [63:0] c);
      logic [7:0]  sub;
      logic [31:0] cl;
      logic [18:0] fa;
      logic [3:0]  msel;
      sub = cmd_byte(c, 3);
      msel = c[55:52];
      case (cmd_byte(c, 0))
         OP_MAP_SET: base_of_map[cmd_byte(c, 5) & 8'h0F] = cmd_word(c, 1);
         OP_FLASH_PGM: begin
            fa = 19'({cmd_byte(c, 1), cmd_byte(c, 2), cmd_byte(c, 3)});
            if (cmd_byte(c, 7) == PGM_ERASE || cmd_byte(c, 7) == PGM_BYTE) loaded[fa] = 1'b1;
         end
         OP_SD_A, OP_SD_B, OP_SD_C: begin
            if ((sub == SD_RD1 || sub == SD_RDM || sub == SD_WR1) && msel != 4'd0) begin
               cl = (cmd_word(c, 4) << 9) >> cur_shift;
               ensure_loaded((cl << 2) + base_of_map[msel], 16);
            end
         end
         OP_CL_SHIFT: cur_shift = 5'(cmd_byte(c, 6) + 8'd9);
         OP_FLASH_A, OP_FLASH_B: cur_offset = '0;
         default: ;
      endcase
      cur_cmd = c;
      send_beat(REQ_COMMAND, c, 19'($urandom), 8'($urandom));
   endtask

   task automatic issue_read();
      logic [7:0] op;
      logic [7:0] mode;
      op = cmd_byte(cur_cmd, 0);
      mode = cmd_byte(cur_cmd, 5);
      if ((op == OP_FLASH_A || op == OP_FLASH_B) &&
          (mode == MODE_WORD_A || mode == MODE_WORD_B || mode == MODE_WORD_C)) begin
         ensure_loaded(base_of_map[0] + cmd_word(cur_cmd, 1) + 32'(cur_offset), 4);
         cur_offset = (cur_offset < 10'd512) ? cur_offset + 10'd4 : 10'd0;
      end
      send_beat(REQ_READ, {$urandom, $urandom}, 19'($urandom), 8'($urandom));
   endtask

   task automatic read_burst(input int n);
      for (int i = 0; i < n; i++) issue_read();
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (rcvd_beats != sent_beats) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   task automatic write_csr(input logic v);
      csr_valid <= 1'b1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [31:0] pick_sector();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return last_sector + $urandom_range(0, 3);
      if (r < 85) return $urandom_range(0, 255);
      return $urandom;
   endfunction

   task automatic random_scenario();
      int          r;
      logic [63:0] c;
      logic [7:0]  modes [6];
      logic [7:0]  subs [8];
      logic [7:0]  misc_ops [8];
      logic [31:0] tgt;
      modes = '{MODE_WORD_A, MODE_WORD_B, MODE_WORD_C, MODE_IMAGE_A, MODE_IMAGE_B,
                8'($urandom)};
      subs = '{SD_STOP, SD_STAT, SD_RD1, SD_RDM, SD_WR1, SD_WRM, SD_OPCOND, 8'($urandom)};
      misc_ops = '{OP_STATUS, OP_HW_VER, OP_ONES, OP_MAGIC, OP_DUMP, OP_CHIP_A, OP_CHIP_B,
                   8'($urandom)};
      r = $urandom_range(0, 99);
      primary_items++;
      if (r < 28) begin
         c = rand_cmd($urandom_range(0, 1) ? OP_FLASH_A : OP_FLASH_B);
         c = with_byte(c, 5, modes[$urandom_range(0, 5)]);
         if ($urandom_range(0, 3) != 0) begin
            // keep most word reads in a small, mostly preloaded flash area
            tgt = $urandom_range(0, 2047) - base_of_map[0];
            c = with_word(c, 1, {13'($urandom), tgt[18:0]});
         end
         issue_cmd(c);
         read_burst(($urandom_range(0, 19) == 0) ? $urandom_range(128, 140)
                                                 : $urandom_range(1, 8));
      end else if (r < 50) begin
         c = rand_cmd(($urandom_range(0, 2) == 0) ? OP_SD_A :
                      ($urandom_range(0, 1) ? OP_SD_B : OP_SD_C));
         c = with_byte(c, 3, subs[$urandom_range(0, 7)]);
         if ($urandom_range(0, 2) == 0) c = with_byte(c, 1, cmd_byte(c, 1) & 8'h0F);
         if ($urandom_range(0, 9) != 0) begin
            last_sector = pick_sector();
            c = with_word(c, 4, last_sector);
         end
         issue_cmd(c);
         read_burst(($urandom_range(0, 29) == 0) ? $urandom_range(128, 135)
                                                 : $urandom_range(0, 10));
      end else if (r < 58) begin
         c = rand_cmd(OP_MAP_SET);
         if ($urandom_range(0, 3) != 0) c = with_word(c, 1, $urandom_range(0, 4095));
         issue_cmd(c);
      end else if (r < 63) begin
         issue_cmd(rand_cmd(OP_CL_SHIFT));
      end else if (r < 68) begin
         c = rand_cmd(OP_FLASH_PGM);
         c = with_byte(c, 7, ($urandom_range(0, 2) == 0) ? PGM_ERASE :
                       ($urandom_range(0, 1) ? PGM_BYTE : 8'($urandom)));
         issue_cmd(c);
      end else if (r < 78) begin
         c = rand_cmd(misc_ops[$urandom_range(0, 7)]);
         if (cmd_byte(c, 0) == OP_DUMP && $urandom_range(0, 1))
            c = {c[63:56], $urandom_range(0, 1) ? DUMP_ADR_A : DUMP_ADR_B, c[31:0]};
         issue_cmd(c);
         read_burst($urandom_range(1, 3));
      end else if (r < 88) begin
         send_preload(19'($urandom), 8'($urandom));
      end else if (r < 91) begin
         send_beat(REQ_UNUSED, {$urandom, $urandom}, 19'($urandom), 8'($urandom));
      end else begin
         issue_read();
      end
   endtask

   task automatic directed_items();
      logic [63:0] c;
      send_preload(19'h00000, 8'hFF);
      send_preload(19'h7FFFF, 8'h00);
      send_beat(REQ_UNUSED, '1, '1, '1);
      issue_cmd(with_byte(with_word(64'd0, 1, 32'd0), 0, OP_MAP_SET));
      // word read wrapping across the top of flash
      c = with_byte(with_word(rand_cmd(OP_FLASH_A), 1, 32'h0007FFFE), 5, MODE_WORD_A);
      issue_cmd(c);
      issue_read();
      issue_cmd(with_byte(rand_cmd(OP_FLASH_B), 5, MODE_IMAGE_A));
      issue_read();
      issue_cmd(with_byte(rand_cmd(OP_FLASH_B), 5, MODE_UNKNOWN));
      issue_read();
      issue_cmd(rand_cmd(OP_CHIP_A));
      issue_read();
      issue_cmd({OP_DUMP, DUMP_ADR_A, 32'h0});
      issue_read();
      issue_cmd(rand_cmd(OP_UNKNOWN));
      issue_read();
      // shift of zero: 9 + 23 wraps to 0
      issue_cmd(with_byte(rand_cmd(OP_CL_SHIFT), 6, 8'd23));
      issue_cmd(with_byte(with_word(with_byte(rand_cmd(OP_SD_A), 1, 8'h50), 4, 32'd7),
                          3, SD_RD1));
      issue_cmd(with_byte(with_word(with_byte(rand_cmd(OP_SD_B), 1, 8'h5F), 4, 32'd8),
                          3, SD_WR1));
      issue_cmd(with_byte(with_word(with_byte(rand_cmd(OP_SD_C), 1, 8'h0A), 4, '1),
                          3, SD_RDM));
      issue_cmd(with_byte(rand_cmd(OP_SD_A), 3, SD_WRM));
      issue_cmd(with_byte(rand_cmd(OP_SD_A), 3, SD_WRM));
      issue_cmd(with_byte(rand_cmd(OP_SD_C), 3, SD_STAT));
      read_burst(3);
      issue_cmd(with_byte(rand_cmd(OP_SD_B), 3, SD_OPCOND));
      issue_read();
      issue_cmd(with_byte(with_byte(rand_cmd(OP_FLASH_PGM), 7, PGM_ERASE), 1, 8'h00));
      issue_cmd(with_byte(with_byte(rand_cmd(OP_FLASH_PGM), 7, PGM_BYTE), 1, 8'hFF));
      issue_cmd(rand_cmd(OP_STATUS));
      issue_read();
   endtask

   initial begin
      for (int i = 0; i < MAP_ENTRIES; i++) base_of_map[i] = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int phase = 0; phase < 4; phase++) begin
         wait_idle();
         write_csr(phase[0]);
         if (phase == 0) directed_items();
         // each phase adds about PHASE_ITEMS request beats
         while (sent_beats < PHASE_ITEMS * (phase + 1)) random_scenario();
      end
      wait_idle();
      $display("covered %0d request beats (%0d scenarios) and %0d result beats",
               sent_beats, primary_items, rcvd_beats);
      $display("card_ejected toggled through both values over 4 phases");
      if (mismatches == 0 && waiting == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule
